FILE: hdl/qte_pkg.sv
// shared constants for the quaternion to euler angles block
// arctangent table, angle limits, rounding and square-root constants; no dependencies
package qte_pkg;

   localparam int IN_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int IN_W = 16;
   localparam int PROD_W = 32;
   localparam int S30_W = 32;
   localparam int ROLL_W = 16;
   localparam int PITCH_W = 15;

   localparam int TABLE_LEN = 32;
   localparam int ANGLE_W = 26;
   localparam int RIGHT_ANGLE = 90 * 65536;
   localparam int ATAN_LIMIT = 23040;
   localparam int ASIN_LIMIT = 11520;
   localparam int ROUND_BIAS = 256;
   localparam int ROUND_SHIFT = 9;

   localparam int ASIN_FRAC = 30;
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_W = 63;
   localparam int SQRT_ONE_SHIFT = 2 * ASIN_FRAC;

   // atan(2^-i) in degrees * 65536
   localparam int ATAN_TAB [TABLE_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

endpackage

FILE: hdl/quaternion_to_euler_angles_top.sv
// quaternion (Q2.14) to ZYX euler angles in 1/128 degree, pipelined CORDIC datapath
// depends on qte_pkg
//
// Takes one quaternion word per cycle while the skid register is empty and
// returns roll, pitch and yaw through these stages in order:
// one product stage, one sum stage, one square stage, one setup stage, the
// 32-stage square-root pipeline for the pitch cosine, one stage per CORDIC
// step, each rotating all three angles at once, and one rounding stage. A skid
// register at the output takes a word the sink refuses; the pipeline and the
// input then hold until the sink takes it. Pitch saturates to +-90 degrees and
// raises pitch_saturated when |2(wy - zx)| exceeds one.
module quaternion_to_euler_angles_top #(
   parameter int IN_FRAC_BITS = qte_pkg::IN_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [qte_pkg::IN_W-1:0] req_q_w,
   input  logic signed [qte_pkg::IN_W-1:0] req_q_x,
   input  logic signed [qte_pkg::IN_W-1:0] req_q_y,
   input  logic signed [qte_pkg::IN_W-1:0] req_q_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [qte_pkg::ROLL_W-1:0] rsp_roll_angle,
   output logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [qte_pkg::ROLL_W-1:0] rsp_yaw_angle,
   output logic rsp_pitch_saturated
);

   localparam int PW = qte_pkg::PROD_W;
   localparam int SW = qte_pkg::S30_W;
   localparam int ZW = qte_pkg::ANGLE_W;
   localparam int RW = qte_pkg::SQRT_W;
   localparam int QW = ZW - qte_pkg::ROUND_SHIFT;
   localparam int MAXB = (2 * IN_FRAC_BITS > 33) ? 2 * IN_FRAC_BITS : 33;
   localparam int CW = MAXB + 4;
   localparam int NCOR = (CORDIC_STEPS < qte_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                             : qte_pkg::TABLE_LEN;
   localparam int P_SQRT0 = 4;
   localparam int P_COR0 = P_SQRT0 + qte_pkg::SQRT_STEPS;
   localparam int P_OUT = P_COR0 + NCOR;
   localparam int NSTAGE = P_OUT + 1;
   localparam int SHR = (2 * IN_FRAC_BITS >= qte_pkg::ASIN_FRAC)
                        ? 2 * IN_FRAC_BITS - qte_pkg::ASIN_FRAC : 0;
   localparam int SHL = (2 * IN_FRAC_BITS < qte_pkg::ASIN_FRAC)
                        ? qte_pkg::ASIN_FRAC - 2 * IN_FRAC_BITS : 0;
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< (2 * IN_FRAC_BITS);

   typedef struct packed {
      logic signed [PW-1:0] p_wx;
      logic signed [PW-1:0] p_yz;
      logic signed [PW-1:0] p_wz;
      logic signed [PW-1:0] p_xy;
      logic signed [PW-1:0] p_xx;
      logic signed [PW-1:0] p_yy;
      logic signed [PW-1:0] p_zz;
      logic signed [PW-1:0] p_wy;
      logic signed [PW-1:0] p_zx;
      logic signed [CW-1:0] roll_x;
      logic signed [CW-1:0] roll_y;
      logic signed [CW-1:0] yaw_x;
      logic signed [CW-1:0] yaw_y;
      logic signed [CW-1:0] pit_x;
      logic signed [CW-1:0] pit_y;
      logic signed [ZW-1:0] roll_a;
      logic signed [ZW-1:0] yaw_a;
      logic signed [ZW-1:0] pit_a;
      logic roll_zero;
      logic yaw_zero;
      logic pit_zero;
      logic sat;
      logic sat_neg;
      logic signed [SW-1:0] s30;
      logic [RW-1:0] rem;
      logic [RW-1:0] root;
      logic signed [qte_pkg::ROLL_W-1:0] roll_o;
      logic signed [qte_pkg::PITCH_W-1:0] pitch_o;
      logic signed [qte_pkg::ROLL_W-1:0] yaw_o;
   } pipe_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] a;
      logic zero;
   } rot_type;

   // fold the left half plane onto the right half plane
   function automatic rot_type pre_rotate(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y);
      rot_type r;
      r.x = x;
      r.y = y;
      r.a = '0;
      r.zero = (x == '0) && (y == '0);
      if (x[CW-1]) begin
         if (!y[CW-1]) begin
            r.x = y;
            r.y = -x;
            r.a = ZW'(qte_pkg::RIGHT_ANGLE);
         end else begin
            r.x = -y;
            r.y = x;
            r.a = -ZW'(qte_pkg::RIGHT_ANGLE);
         end
      end
      return r;
   endfunction

   function automatic rot_type cordic_step(input rot_type v, input int sh);
      rot_type r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = v.y >>> sh;
      dy = v.x >>> sh;
      r = v;
      if (!v.y[CW-1]) begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.a = v.a + ZW'(qte_pkg::ATAN_TAB[sh]);
      end else begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.a = v.a - ZW'(qte_pkg::ATAN_TAB[sh]);
      end
      return r;
   endfunction

   function automatic logic signed [QW-1:0] round_clamp(input logic signed [ZW-1:0] a,
                                                        input int limit);
      logic signed [ZW-1:0] t;
      logic signed [QW-1:0] r;
      t = a + ZW'(qte_pkg::ROUND_BIAS);
      r = QW'(t >>> qte_pkg::ROUND_SHIFT);
      if (r > QW'(limit)) begin
         r = QW'(limit);
      end else if (r < -QW'(limit)) begin
         r = -QW'(limit);
      end
      return r;
   endfunction

   pipe_type pipe_ff [NSTAGE];
   pipe_type pipe_in [NSTAGE];
   pipe_type skid_ff;
   logic [NSTAGE-1:0] valid_ff;
   logic skid_valid_ff;
   logic advance;

   assign advance = !skid_valid_ff;
   assign req_ready = advance;

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      if (g == 0) begin : g_prod
         pipe_type nx;
         always_comb begin
            nx = '0;
            nx.p_wx = PW'(req_q_w) * PW'(req_q_x);
            nx.p_yz = PW'(req_q_y) * PW'(req_q_z);
            nx.p_wz = PW'(req_q_w) * PW'(req_q_z);
            nx.p_xy = PW'(req_q_x) * PW'(req_q_y);
            nx.p_xx = PW'(req_q_x) * PW'(req_q_x);
            nx.p_yy = PW'(req_q_y) * PW'(req_q_y);
            nx.p_zz = PW'(req_q_z) * PW'(req_q_z);
            nx.p_wy = PW'(req_q_w) * PW'(req_q_y);
            nx.p_zx = PW'(req_q_z) * PW'(req_q_x);
         end
         assign pipe_in[g] = nx;
      end else if (g == 1) begin : g_sum
         pipe_type nx;
         logic signed [CW-1:0] s;
         logic signed [CW-1:0] s_sh;
         always_comb begin
            nx = pipe_ff[g-1];
            nx.roll_y = (CW'(pipe_ff[g-1].p_wx) + CW'(pipe_ff[g-1].p_yz)) <<< 1;
            nx.roll_x = ONE - ((CW'(pipe_ff[g-1].p_xx) + CW'(pipe_ff[g-1].p_yy)) <<< 1);
            nx.yaw_y = (CW'(pipe_ff[g-1].p_wz) + CW'(pipe_ff[g-1].p_xy)) <<< 1;
            nx.yaw_x = ONE - ((CW'(pipe_ff[g-1].p_yy) + CW'(pipe_ff[g-1].p_zz)) <<< 1);
            s = (CW'(pipe_ff[g-1].p_wy) - CW'(pipe_ff[g-1].p_zx)) <<< 1;
            nx.sat = (s > ONE) || (s < -ONE);
            nx.sat_neg = s[CW-1];
            s_sh = (2 * IN_FRAC_BITS >= qte_pkg::ASIN_FRAC) ? (s >>> SHR) : (s <<< SHL);
            nx.s30 = SW'(s_sh);
         end
         assign pipe_in[g] = nx;
      end else if (g == 2) begin : g_square
         pipe_type nx;
         rot_type rr;
         rot_type yr;
         logic signed [2*SW-1:0] sq_full;
         always_comb begin
            nx = pipe_ff[g-1];
            sq_full = pipe_ff[g-1].s30 * pipe_ff[g-1].s30;
            nx.rem = sq_full[RW-1:0];
            rr = pre_rotate(pipe_ff[g-1].roll_x, pipe_ff[g-1].roll_y);
            yr = pre_rotate(pipe_ff[g-1].yaw_x, pipe_ff[g-1].yaw_y);
            nx.roll_x = rr.x;
            nx.roll_y = rr.y;
            nx.roll_a = rr.a;
            nx.roll_zero = rr.zero;
            nx.yaw_x = yr.x;
            nx.yaw_y = yr.y;
            nx.yaw_a = yr.a;
            nx.yaw_zero = yr.zero;
         end
         assign pipe_in[g] = nx;
      end else if (g == 3) begin : g_setup
         pipe_type nx;
         always_comb begin
            nx = pipe_ff[g-1];
            nx.rem = (RW'(1) << qte_pkg::SQRT_ONE_SHIFT) - pipe_ff[g-1].rem;
            nx.root = '0;
         end
         assign pipe_in[g] = nx;
      end else if (g < P_COR0) begin : g_sqrt
         localparam int K = g - P_SQRT0;
         localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * K);
         pipe_type nx;
         logic [RW-1:0] cand;
         always_comb begin
            nx = pipe_ff[g-1];
            cand = pipe_ff[g-1].root + BIT;
            if (pipe_ff[g-1].rem >= cand) begin
               nx.rem = pipe_ff[g-1].rem - cand;
               nx.root = (pipe_ff[g-1].root >> 1) + BIT;
            end else begin
               nx.root = pipe_ff[g-1].root >> 1;
            end
            // last root bit: load the pitch vector
            if (K == qte_pkg::SQRT_STEPS - 1) begin
               nx.pit_x = CW'(nx.root);
               nx.pit_y = CW'(pipe_ff[g-1].s30);
               nx.pit_a = '0;
               nx.pit_zero = (pipe_ff[g-1].s30 == '0) && (nx.root == '0);
            end
         end
         assign pipe_in[g] = nx;
      end else if (g < P_OUT) begin : g_cordic
         localparam int I = g - P_COR0;
         pipe_type nx;
         rot_type rr;
         rot_type yr;
         rot_type pr;
         always_comb begin
            nx = pipe_ff[g-1];
            rr = cordic_step({pipe_ff[g-1].roll_x, pipe_ff[g-1].roll_y,
                              pipe_ff[g-1].roll_a, pipe_ff[g-1].roll_zero}, I);
            yr = cordic_step({pipe_ff[g-1].yaw_x, pipe_ff[g-1].yaw_y,
                              pipe_ff[g-1].yaw_a, pipe_ff[g-1].yaw_zero}, I);
            pr = cordic_step({pipe_ff[g-1].pit_x, pipe_ff[g-1].pit_y,
                              pipe_ff[g-1].pit_a, pipe_ff[g-1].pit_zero}, I);
            nx.roll_x = rr.x;
            nx.roll_y = rr.y;
            nx.roll_a = rr.a;
            nx.yaw_x = yr.x;
            nx.yaw_y = yr.y;
            nx.yaw_a = yr.a;
            nx.pit_x = pr.x;
            nx.pit_y = pr.y;
            nx.pit_a = pr.a;
         end
         assign pipe_in[g] = nx;
      end else begin : g_round
         pipe_type nx;
         always_comb begin
            nx = pipe_ff[g-1];
            nx.roll_o = pipe_ff[g-1].roll_zero ? '0
                      : qte_pkg::ROLL_W'(round_clamp(pipe_ff[g-1].roll_a, qte_pkg::ATAN_LIMIT));
            nx.yaw_o = pipe_ff[g-1].yaw_zero ? '0
                     : qte_pkg::ROLL_W'(round_clamp(pipe_ff[g-1].yaw_a, qte_pkg::ATAN_LIMIT));
            if (pipe_ff[g-1].sat) begin
               nx.pitch_o = pipe_ff[g-1].sat_neg ? -qte_pkg::PITCH_W'(qte_pkg::ASIN_LIMIT)
                                                 : qte_pkg::PITCH_W'(qte_pkg::ASIN_LIMIT);
            end else if (pipe_ff[g-1].pit_zero) begin
               nx.pitch_o = '0;
            end else begin
               nx.pitch_o = qte_pkg::PITCH_W'(round_clamp(pipe_ff[g-1].pit_a,
                                                          qte_pkg::ASIN_LIMIT));
            end
         end
         assign pipe_in[g] = nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= {valid_ff[NSTAGE-2:0], req_valid};
         end
         if (skid_valid_ff) begin
            if (rsp_ready) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (valid_ff[P_OUT] && !rsp_ready) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NSTAGE; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
         skid_ff <= pipe_ff[P_OUT];
      end
   end

   // older word waits in the skid register
   assign rsp_valid = skid_valid_ff || valid_ff[P_OUT];
   assign rsp_roll_angle = skid_valid_ff ? skid_ff.roll_o : pipe_ff[P_OUT].roll_o;
   assign rsp_pitch_angle = skid_valid_ff ? skid_ff.pitch_o : pipe_ff[P_OUT].pitch_o;
   assign rsp_yaw_angle = skid_valid_ff ? skid_ff.yaw_o : pipe_ff[P_OUT].yaw_o;
   assign rsp_pitch_saturated = skid_valid_ff ? skid_ff.sat : pipe_ff[P_OUT].sat;

endmodule
